### src/qyaw_pkg.sv
// Shared constants, types and the arctangent table for the quaternion yaw block.
`timescale 1ns / 1ps
package qyaw_pkg;

    localparam int Q_W              = 32;
    localparam int VEC_W            = 62;
    localparam int ANG_W            = 34;
    localparam int ANG_FRAC         = 24;
    localparam int ATAN_N           = 24;
    localparam int CALIB_W          = 7;
    localparam int YAW_W            = 17;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int YAW_FRAC_DEF     = 8;
    localparam logic [CALIB_W-1:0] CALIB_FRAMES_RST = CALIB_W'(50);

    typedef struct packed {
        logic                    vld;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] ang;
    } cord_t;

    // atan(2^-i) in degrees with 24 fraction bits, rounded to nearest.
    function automatic logic signed [ANG_W-1:0] atan_deg(input int idx);
        logic signed [ANG_W-1:0] v;
        begin
            unique case (idx)
                0:  v = ANG_W'(754974720);
                1:  v = ANG_W'(445687602);
                2:  v = ANG_W'(235489088);
                3:  v = ANG_W'(119537938);
                4:  v = ANG_W'(60000934);
                5:  v = ANG_W'(30029717);
                6:  v = ANG_W'(15018523);
                7:  v = ANG_W'(7509720);
                8:  v = ANG_W'(3754917);
                9:  v = ANG_W'(1877466);
                10: v = ANG_W'(938734);
                11: v = ANG_W'(469367);
                12: v = ANG_W'(234684);
                13: v = ANG_W'(117342);
                14: v = ANG_W'(58671);
                15: v = ANG_W'(29335);
                16: v = ANG_W'(14668);
                17: v = ANG_W'(7334);
                18: v = ANG_W'(3667);
                19: v = ANG_W'(1833);
                20: v = ANG_W'(917);
                21: v = ANG_W'(458);
                22: v = ANG_W'(229);
                23: v = ANG_W'(115);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

### src/qyaw_if.sv
// Channel interfaces: quaternion samples in, yaw results out, configuration writes.
`timescale 1ns / 1ps
interface qyaw_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [qyaw_pkg::Q_W-1:0] quat_w;
    logic signed [qyaw_pkg::Q_W-1:0] quat_x;
    logic signed [qyaw_pkg::Q_W-1:0] quat_y;
    logic signed [qyaw_pkg::Q_W-1:0] quat_z;
    logic                            quat_present;
    logic                            calibrate;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, quat_present, calibrate,
                    input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, quat_present, calibrate,
                    output ready);
endinterface

interface qyaw_out_if;
    logic                              valid;
    logic                              ready;
    logic                              status;
    logic signed [qyaw_pkg::YAW_W-1:0] raw_yaw;
    logic signed [qyaw_pkg::YAW_W-1:0] relative_yaw;
    logic                              offset_ready_out;
    logic                              calib_done;

    modport source (output valid, status, raw_yaw, relative_yaw, offset_ready_out,
                    calib_done, input ready);
    modport sink   (input valid, status, raw_yaw, relative_yaw, offset_ready_out,
                    calib_done, output ready);
endinterface

interface qyaw_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [qyaw_pkg::CALIB_W-1:0]      data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### src/qyaw_cell.sv
// One CORDIC vectoring cell: a single micro-rotation, registered toward the next cell.
`timescale 1ns / 1ps
module qyaw_cell #(
    parameter int STEP = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  qyaw_pkg::cord_t cin,
    output qyaw_pkg::cord_t cout
);
    import qyaw_pkg::*;

    localparam logic signed [ANG_W-1:0] ATAN_K = atan_deg(STEP);

    logic                    vld_reg;
    logic signed [VEC_W-1:0] x_reg, x_next;
    logic signed [VEC_W-1:0] y_reg, y_next;
    logic signed [ANG_W-1:0] ang_reg, ang_next;

    always_comb
    begin
        if (!cin.y[VEC_W-1])
        begin
            x_next   = cin.x + (cin.y >>> STEP);
            y_next   = cin.y - (cin.x >>> STEP);
            ang_next = cin.ang + ATAN_K;
        end
        else
        begin
            x_next   = cin.x - (cin.y >>> STEP);
            y_next   = cin.y + (cin.x >>> STEP);
            ang_next = cin.ang - ATAN_K;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= cin.vld;
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        ang_reg <= ang_next;
    end

    assign cout = '{vld: vld_reg, x: x_reg, y: y_reg, ang: ang_reg};

endmodule

### src/qyaw_div.sv
// Restoring divider, one quotient bit per cycle, for the calibration mean.
`timescale 1ns / 1ps
module qyaw_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (go)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    done_reg <= 1'b0;
            end
            else
                done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

### src/quaternion_yaw_zero_offset.sv
// Top level: quaternion to yaw through a CORDIC cell chain, with zero-offset calibration.
//
//  channel  | direction | beat contents
//  ---------+-----------+-----------------------------------------------------------
//  sample   | in        | quat_w/x/y/z (Q30), quat_present, calibrate
//  result   | out       | status, raw_yaw, relative_yaw, offset_ready_out, calib_done
//  cfg      | in        | data = calib_frames
//
// One sample is in flight at a time: the six products are formed and summed on the
// shared 32x32 multiplier, the vector is folded, run through the cell chain and then
// handled by the control states before the next beat is accepted. A beat that ends a
// calibration run with valid samples also passes through the serial divider. The next
// sample is taken while a result still waits on a stalled result channel. Reset clears
// all calibration state.
`timescale 1ns / 1ps
module quaternion_yaw_zero_offset #(
    parameter int CORDIC_STEPS  = qyaw_pkg::CORDIC_STEPS_DEF,
    parameter int YAW_FRAC_BITS = qyaw_pkg::YAW_FRAC_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    qyaw_in_if.sink   sample,
    qyaw_out_if.source result,
    qyaw_cfg_if.sink  cfg
);
    import qyaw_pkg::*;

    localparam int RAW_W = YAW_FRAC_BITS + 9;
    localparam int SUM_W = RAW_W + CALIB_W;
    localparam int NUM_W = SUM_W + 1;
    localparam int DEN_W = CALIB_W + 1;
    localparam int DIF_W = RAW_W + 2;
    localparam int SH    = ANG_FRAC - YAW_FRAC_BITS;
    localparam logic signed [ANG_W-1:0] ANG_HALF = ANG_W'(64'sd1 <<< (SH - 1));
    localparam logic signed [ANG_W-1:0] ANG_LIM  = ANG_W'(64'sd180 <<< YAW_FRAC_BITS);
    localparam logic signed [ANG_W-1:0] ANG_90   = ANG_W'(64'sd90 <<< ANG_FRAC);
    localparam logic signed [DIF_W-1:0] DIF_LIM  = DIF_W'(64'sd180 <<< YAW_FRAC_BITS);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_PRE, S_CORD, S_CAL, S_DIV, S_REL, S_EMIT
    } state_t;

    state_t state_reg;

    logic [CALIB_W-1:0]      frames_reg;
    logic signed [Q_W-1:0]   qw_reg, qx_reg, qy_reg, qz_reg;
    logic                    present_reg, calib_reg;
    logic [2:0]              mul_cnt_reg;
    logic [2:0]              prod_sel_reg;
    logic signed [63:0]      prod_reg;
    logic signed [VEC_W-1:0] vx_reg, vy_reg;
    logic                    zero_reg;
    logic signed [RAW_W-1:0] raw_reg, rel_reg, off_reg;
    logic                    ready_reg, done_reg;
    logic [CALIB_W-1:0]      att_reg, val_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    neg_reg, div_go_reg;
    logic [NUM_W-1:0]        div_num_reg;
    logic [DEN_W-1:0]        div_den_reg;
    logic                    out_vld_reg, out_status_reg, out_ready_reg, out_done_reg;
    logic signed [YAW_W-1:0] out_raw_reg, out_rel_reg;

    logic signed [Q_W-1:0]   op_a, op_b;
    logic signed [63:0]      prod_adj;
    logic signed [VEC_W-1:0] prod_q;
    cord_t                   chain [0:CORDIC_STEPS];
    logic signed [ANG_W-1:0] ang_rnd;
    logic signed [RAW_W-1:0] raw_c;
    logic [CALIB_W-1:0]      need, att_n, val_n;
    logic signed [SUM_W-1:0] sum_n;
    logic [SUM_W-1:0]        mag_n;
    logic signed [DIF_W-1:0] dif, dif_w;
    logic                    div_done;
    logic [NUM_W-1:0]        div_quo;
    logic                    out_take, out_free;

    // Operand selection for the six products, one per cycle.
    always_comb
    begin
        unique case (mul_cnt_reg)
            3'd0:    begin op_a = qw_reg; op_b = qw_reg; end
            3'd1:    begin op_a = qx_reg; op_b = qx_reg; end
            3'd2:    begin op_a = qy_reg; op_b = qy_reg; end
            3'd3:    begin op_a = qz_reg; op_b = qz_reg; end
            3'd4:    begin op_a = qx_reg; op_b = qy_reg; end
            default: begin op_a = qw_reg; op_b = qz_reg; end
        endcase
    end

    // Division by 16 truncates toward zero.
    assign prod_adj = prod_reg + (prod_reg[63] ? 64'sd15 : 64'sd0);
    assign prod_q   = VEC_W'(prod_adj >>> 4);

    // Second and third quadrant vectors are turned by 90 degrees before the chain.
    always_comb
    begin
        chain[0].vld = (state_reg == S_PRE);
        if (vx_reg[VEC_W-1] && !vy_reg[VEC_W-1])
        begin
            chain[0].x   = vy_reg;
            chain[0].y   = -vx_reg;
            chain[0].ang = ANG_90;
        end
        else if (vx_reg[VEC_W-1])
        begin
            chain[0].x   = -vy_reg;
            chain[0].y   = vx_reg;
            chain[0].ang = -ANG_90;
        end
        else
        begin
            chain[0].x   = vx_reg;
            chain[0].y   = vy_reg;
            chain[0].ang = '0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        qyaw_cell #(.STEP(i)) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .cin  (chain[i]),
            .cout (chain[i+1])
        );
    end

    always_comb
    begin
        ang_rnd = (chain[CORDIC_STEPS].ang + ANG_HALF) >>> SH;
        if (ang_rnd > ANG_LIM)
            raw_c = RAW_W'(ANG_LIM);
        else if (ang_rnd < -ANG_LIM)
            raw_c = RAW_W'(-ANG_LIM);
        else
            raw_c = RAW_W'(ang_rnd);
    end

    // Calibration bookkeeping for the current beat.
    always_comb
    begin
        need  = (frames_reg == '0) ? CALIB_W'(1) : frames_reg;
        att_n = att_reg + 1'b1;
        sum_n = present_reg ? sum_reg + SUM_W'(raw_reg) : sum_reg;
        val_n = present_reg ? val_reg + 1'b1 : val_reg;
        mag_n = sum_n[SUM_W-1] ? SUM_W'(-sum_n) : SUM_W'(sum_n);
    end

    always_comb
    begin
        dif = DIF_W'(raw_reg) - DIF_W'(off_reg);
        if (dif > DIF_LIM)
            dif_w = dif - (DIF_LIM <<< 1);
        else if (dif < -DIF_LIM)
            dif_w = dif + (DIF_LIM <<< 1);
        else
            dif_w = dif;
    end

    qyaw_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (div_go_reg),
        .num  (div_num_reg),
        .den  (div_den_reg),
        .done (div_done),
        .quo  (div_quo)
    );

    assign out_take = out_vld_reg && result.ready;
    assign out_free = !out_vld_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            frames_reg   <= CALIB_FRAMES_RST;
            att_reg      <= '0;
            val_reg      <= '0;
            sum_reg      <= '0;
            off_reg      <= '0;
            ready_reg    <= 1'b0;
            done_reg     <= 1'b0;
            div_go_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            mul_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg.valid)
                frames_reg <= cfg.data;
            // In the emit state a taken beat is replaced by the new one below.
            if (out_take && (state_reg != S_EMIT))
                out_vld_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (sample.valid)
                    begin
                        qw_reg      <= sample.quat_w;
                        qx_reg      <= sample.quat_x;
                        qy_reg      <= sample.quat_y;
                        qz_reg      <= sample.quat_z;
                        present_reg <= sample.quat_present;
                        calib_reg   <= sample.calibrate;
                        vx_reg      <= '0;
                        vy_reg      <= '0;
                        mul_cnt_reg <= '0;
                        done_reg    <= 1'b0;
                        state_reg   <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (mul_cnt_reg != 3'd6)
                    begin
                        prod_reg     <= op_a * op_b;
                        prod_sel_reg <= mul_cnt_reg;
                    end
                    if (mul_cnt_reg != 3'd0)
                    begin
                        unique case (prod_sel_reg)
                            3'd0, 3'd1: vx_reg <= vx_reg + prod_q;
                            3'd2, 3'd3: vx_reg <= vx_reg - prod_q;
                            default:    vy_reg <= vy_reg + (prod_q <<< 1);
                        endcase
                    end
                    if (mul_cnt_reg == 3'd6)
                        state_reg <= S_PRE;
                    else
                        mul_cnt_reg <= mul_cnt_reg + 1'b1;
                end
                S_PRE:
                begin
                    zero_reg  <= (vx_reg == '0) && (vy_reg == '0);
                    state_reg <= S_CORD;
                end
                S_CORD:
                begin
                    if (chain[CORDIC_STEPS].vld)
                    begin
                        raw_reg   <= (zero_reg || !present_reg) ? '0 : raw_c;
                        state_reg <= S_CAL;
                    end
                end
                S_CAL:
                begin
                    if (calib_reg && (att_n >= need))
                    begin
                        done_reg <= 1'b1;
                        att_reg  <= '0;
                        val_reg  <= '0;
                        sum_reg  <= '0;
                        if (val_n != '0)
                        begin
                            neg_reg     <= sum_n[SUM_W-1];
                            div_num_reg <= {mag_n, 1'b0} + NUM_W'(val_n);
                            div_den_reg <= {val_n, 1'b0};
                            div_go_reg  <= 1'b1;
                            state_reg   <= S_DIV;
                        end
                        else
                            state_reg <= S_REL;
                    end
                    else
                    begin
                        if (calib_reg)
                        begin
                            att_reg <= att_n;
                            val_reg <= val_n;
                            sum_reg <= sum_n;
                        end
                        state_reg <= S_REL;
                    end
                end
                S_DIV:
                begin
                    div_go_reg <= 1'b0;
                    if (div_done)
                    begin
                        off_reg   <= neg_reg ? -RAW_W'(div_quo) : RAW_W'(div_quo);
                        ready_reg <= 1'b1;
                        state_reg <= S_REL;
                    end
                end
                S_REL:
                begin
                    if (!present_reg)
                        rel_reg <= '0;
                    else if (ready_reg)
                        rel_reg <= RAW_W'(dif_w);
                    else
                        rel_reg <= raw_reg;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_vld_reg    <= 1'b1;
                        out_status_reg <= !present_reg;
                        out_raw_reg    <= YAW_W'(raw_reg);
                        out_rel_reg    <= YAW_W'(rel_reg);
                        out_ready_reg  <= ready_reg;
                        out_done_reg   <= done_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign sample.ready            = (state_reg == S_IDLE);
    assign cfg.ready               = 1'b1;
    assign result.valid            = out_vld_reg;
    assign result.status           = out_status_reg;
    assign result.raw_yaw          = out_raw_reg;
    assign result.relative_yaw     = out_rel_reg;
    assign result.offset_ready_out = out_ready_reg;
    assign result.calib_done       = out_done_reg;

endmodule

### src/qyaw_chk.sv
// Port-level checker for the quaternion yaw block, bound to the top level.
`timescale 1ns / 1ps
module qyaw_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              status,
    input logic signed [qyaw_pkg::YAW_W-1:0] raw_yaw,
    input logic signed [qyaw_pkg::YAW_W-1:0] relative_yaw,
    input logic                              offset_ready_out
);
    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // A sample beat occupies the datapath, so the next cycle cannot take another.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second sample taken while one is in flight");

    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> raw_yaw == '0 && relative_yaw == '0)
        else $error("missing quaternion gave nonzero yaw");

    a_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !offset_ready_out |-> relative_yaw == raw_yaw)
        else $error("relative yaw differs from raw yaw before calibration");

endmodule

bind quaternion_yaw_zero_offset qyaw_chk u_qyaw_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (sample.valid),
    .in_ready        (sample.ready),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .status          (result.status),
    .raw_yaw         (result.raw_yaw),
    .relative_yaw    (result.relative_yaw),
    .offset_ready_out(result.offset_ready_out)
);
